// File: hw/rtl/ssb_pkg.sv
// Shared types and constants for the SPI master byte shifter.
`default_nettype none
package ssb_pkg;

    localparam int WORD_BITS_DEF   = 8;
    localparam int CMD_W           = 8;
    localparam int RX_W            = 8;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [APB_ADDR_W-3:0] REG_PHASE_DELAY = '0;
    localparam logic [7:0]            PHASE_DELAY_RST = 8'd10;

    // One tick of the bit sequencer as offered on the input stream.
    typedef struct packed {
        logic             cmd_valid;
        logic [CMD_W-1:0] cmd_byte;
        logic             cmd_last;
        logic             miso;
    } t_tick;

    // Pin levels and receive status after one tick.
    typedef struct packed {
        logic            sck;
        logic            mosi;
        logic            cs_n;
        logic            ready_res;
        logic            rx_valid;
        logic [RX_W-1:0] rx_byte;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/ssb_front.sv
// Input stage: takes stream transfers, unpacks them and feeds the tick queue.
`default_nettype none
module ssb_front
    import ssb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic                  i_tuser,
    input  wire logic                  i_tlast,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_tick                      o_tick
);

    logic  r_valid;
    t_tick r_tick;
    t_tick n_tick;

    always_comb begin
        n_tick.cmd_valid = i_tuser;
        n_tick.cmd_byte  = i_tdata[CMD_W-1:0];
        n_tick.cmd_last  = i_tlast;
        n_tick.miso      = i_tdata[CMD_W];
    end

    // Hold the staged tick until the queue has room.
    assign o_tready = !r_valid || !i_q_full;
    assign o_push   = r_valid && !i_q_full;
    assign o_tick   = r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
        if (o_tready && i_tvalid) begin
            r_tick <= n_tick;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ssb_queue.sv
// Small register queue between the input stage and the bit sequencer.
`default_nettype none
module ssb_queue
    import ssb_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ssb_back.sv
// Bit sequencer: runs one tick per queued item and registers the pin levels.
`default_nettype none
module ssb_back
    import ssb_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_phase_delay,
    input  wire logic       i_q_valid,
    input  wire t_tick      i_tick,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_result
);

    localparam int BL_W = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_SETUP, PH_HIGH, PH_LOW} t_phase;

    t_phase               r_phase,   n_phase;
    logic [WORD_BITS-1:0] r_shift,   n_shift;
    logic [BL_W-1:0]      r_bits,    n_bits;
    logic [7:0]           r_delay,   n_delay;
    logic                 r_sel,     n_sel;
    logic                 r_release, n_release;
    logic                 r_mosi,    n_mosi;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic [7:0]               dly;
    logic                     phase_done;
    logic                     rx_valid;
    logic [WORD_BITS+CMD_W-1:0] cmd_ext;
    logic [WORD_BITS+RX_W-1:0]  rx_ext;

    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign dly     = (i_phase_delay == 8'd0) ? 8'd1 : i_phase_delay;
    assign cmd_ext = {{WORD_BITS{1'b0}}, i_tick.cmd_byte};
    assign rx_ext  = {{RX_W{1'b0}}, r_shift};

    always_comb begin
        n_phase    = r_phase;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_delay    = r_delay;
        n_sel      = r_sel;
        n_release  = r_release;
        n_mosi     = r_mosi;
        rx_valid   = 1'b0;
        phase_done = 1'b0;

        if (r_phase != PH_IDLE) begin
            if (r_delay > 8'd1) begin
                n_delay = r_delay - 8'd1;
            end else begin
                phase_done = 1'b1;
            end
        end

        case (r_phase)
            PH_IDLE: begin
                if (i_tick.cmd_valid) begin
                    n_shift   = cmd_ext[WORD_BITS-1:0];
                    n_bits    = BL_W'(WORD_BITS);
                    n_release = i_tick.cmd_last;
                    n_sel     = 1'b1;
                    n_mosi    = cmd_ext[WORD_BITS-1];
                    n_phase   = PH_SETUP;
                    n_delay   = dly;
                end
            end
            PH_SETUP: begin
                if (phase_done) begin
                    n_phase = PH_HIGH;
                    n_delay = dly;
                end
            end
            PH_HIGH: begin
                // Sample MISO on the last tick before SCK falls.
                if (phase_done) begin
                    n_shift = {r_shift[WORD_BITS-2:0], i_tick.miso};
                    if (r_bits != '0) begin
                        n_bits = r_bits - BL_W'(1);
                    end
                    n_phase = PH_LOW;
                    n_delay = dly;
                end
            end
            PH_LOW: begin
                if (phase_done) begin
                    if (r_bits != '0) begin
                        n_mosi  = r_shift[WORD_BITS-1];
                        n_phase = PH_SETUP;
                        n_delay = dly;
                    end else begin
                        rx_valid = 1'b1;
                        if (r_release) begin
                            n_sel     = 1'b0;
                            n_mosi    = 1'b1;
                            n_release = 1'b0;
                        end
                        n_phase = PH_IDLE;
                        n_delay = 8'd0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_out.sck       = (n_phase == PH_HIGH);
        n_out.mosi      = n_mosi;
        n_out.cs_n      = !n_sel;
        n_out.ready_res = (n_phase == PH_IDLE);
        n_out.rx_valid  = rx_valid;
        n_out.rx_byte   = rx_valid ? rx_ext[RX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_bits      <= '0;
            r_delay     <= 8'd0;
            r_sel       <= 1'b0;
            r_release   <= 1'b0;
            r_mosi      <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_delay     <= n_delay;
            r_sel       <= n_sel;
            r_release   <= n_release;
            r_mosi      <= n_mosi;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/spi_master_byte_shifter_unit.sv
// Top level of the SPI master byte shifter: stream ports, register port, core.
//
// SPI master in mode 0, most significant bit first. Every input transfer is
// one tick of the bit sequencer and yields exactly one output transfer with
// the SCK, MOSI and chip-select levels after that tick, plus the received
// word on the tick it completes. One transfer is taken per clock in steady
// state while the output is not stalled. A result passes through the input
// stage register, the tick queue entry and the output register, which the
// sequencer step writes, before it can transfer. The sequencer advances one
// tick per cycle while the output accepts results, which sets the throughput.
// Each bit spends phase_delay ticks with SCK low, high and low again
// (register 0, reset 10, 0 acts as 1); write it only while no transfer is
// in flight.
`default_nettype none
module spi_master_byte_shifter_unit
    import ssb_pkg::*;
#(
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input ticks
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] cmd_byte, [8] miso, [15:9] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd_valid
    input  wire logic                   s_axis_tuser,
    input  wire logic                   s_axis_tlast,
    // Results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] sck, [1] mosi, [2] cs_n, [3] ready_res, [11:4] rx_byte, [15:12] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] rx_valid
    output logic                        m_axis_tuser,
    // Register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int TICK_W = $bits(t_tick);

    logic       reg_wr;
    logic [7:0] r_phase_delay_q;
    logic       reg_hit;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    t_tick             front_tick;
    logic [TICK_W-1:0] q_data;
    t_tick             back_tick;
    t_result           result;

    // Register file: a single delay register.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_PHASE_DELAY);
    assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {{(APB_DATA_W-8){1'b0}}, r_phase_delay_q} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_delay_q <= PHASE_DELAY_RST;
        end else if (reg_wr) begin
            r_phase_delay_q <= pwdata[7:0];
        end
    end

    ssb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_tick   (front_tick)
    );

    ssb_queue #(
        .WIDTH (TICK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_tick),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign back_tick = t_tick'(q_data);

    ssb_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_delay (r_phase_delay_q),
        .i_q_valid     (q_valid),
        .i_tick        (back_tick),
        .o_pop         (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-4-RX_W){1'b0}}, result.rx_byte,
                           result.ready_res, result.cs_n, result.mosi, result.sck};
    assign m_axis_tuser = result.rx_valid;

endmodule
`default_nettype wire

// File: hw/rtl/ssb_checker.sv
// Port-level checks for the SPI master byte shifter, bound to the top level.
`default_nettype none
module ssb_checker
    import ssb_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // SCK only pulses with chip select asserted.
    a_sck_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[2] && !m_axis_tdata[3])
        else $error("sck high outside an active word");

    // A completed word leaves the sequencer idle.
    a_rx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3])
        else $error("received word reported while busy");

    // Released chip select always comes with MOSI idling high.
    a_cs_mosi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("mosi low with chip select released");

endmodule

bind spi_master_byte_shifter_unit ssb_checker u_ssb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
